// ===== sv/sbap_pkg.sv =====
package sbap_pkg;

    // Queue shape and per-entry charge
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ENTRY_OVERHEAD  = 256;

    // Field widths
    localparam int COST_W     = 33;
    localparam int BACKLOG_W  = 40;
    localparam int RATE_W     = 32;
    localparam int BYTES_W    = 32;
    localparam int NS_W       = 62;
    localparam int SENT_W     = 64;
    localparam int QCOUNT_W   = 7;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;

    // Pacing divider: one quotient bit per cycle
    localparam int DIV_BITS  = NS_W;
    localparam int DIV_CNT_W = $clog2(DIV_BITS);

    localparam logic [29:0] NANOS_PER_SEC = 30'd1000000000;

    localparam logic [BACKLOG_W-1:0] MAX_BACKLOG_RST = 40'd1048576;
    localparam logic [RATE_W-1:0]    RATE_LIMIT_RST  = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BACKLOG     = 2'd0,
        CFG_RATE_LIMIT      = 2'd1,
        CFG_THROTTLE_ENABLE = 2'd2,
        CFG_LOSSY_MODE      = 2'd3
    } sbap_cfg_idx_t;

    typedef enum logic [1:0] {
        FUNC_SUBMIT   = 2'd0,
        FUNC_TX_DONE  = 2'd1,
        FUNC_COMPLETE = 2'd2,
        FUNC_STOP     = 2'd3
    } sbap_func_t;

    typedef enum logic [3:0] {
        STAT_STARTED      = 4'd0,
        STAT_QUEUED       = 4'd1,
        STAT_DROPPED      = 4'd2,
        STAT_BACKLOG_STOP = 4'd3,
        STAT_ABORTED      = 4'd4,
        STAT_PACED        = 4'd5,
        STAT_NEXT_STARTED = 4'd6,
        STAT_IDLE         = 4'd7,
        STAT_EMPTY        = 4'd8,
        STAT_STOPPED      = 4'd9
    } sbap_status_t;

    typedef struct packed {
        sbap_func_t         func;
        logic [31:0]        payload_cost;
        logic               closing;
        logic [BYTES_W-1:0] byte_count;
        logic [NS_W-1:0]    elapsed_ns;
    } sbap_in_t;

    typedef struct packed {
        sbap_status_t         status;
        logic [NS_W-1:0]      delay_ns;
        logic [BACKLOG_W-1:0] backlog_now;
        logic [QCOUNT_W-1:0]  queue_count;
        logic [SENT_W-1:0]    sent_total;
    } sbap_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } sbap_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pace_on;
    } sbap_stat_t;

endpackage

// ===== sv/send_backlog_admission_pacer_core.sv =====
// Send queue admission and pacing.
// The s_ channel carries one event per transfer: submit, transmit done, send
// completion or external stop. Every event produces exactly one result transfer
// on the m_ channel with a status code, the pacing delay (transmit done only),
// and the backlog, queue count and sent-byte total after the event.
// Each accepted event is registered, then its result is committed to the output
// register. A transmit done with pacing active first forms the bytes * 1e9
// product and runs the restoring divider, one quotient bit per cycle, before
// the result step. A new event is taken only after the last result is committed.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata); write
// it only between events.
// Reset (aresetn low, synchronous) empties the queue, clears backlog, sent count
// and stop flag, and loads the register defaults. No clearing pass is needed.
// When the receiver stalls, the result holds in the output register; the block
// takes the next event and finishes its work, then waits until the held result
// is taken before presenting a new one.
module send_backlog_admission_pacer_core import sbap_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sbap_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sbap_out_t             m_data
);

    sbap_cmd_t  cmd;
    sbap_stat_t stat;

    // Sequence accept, multiply, divide and result steps
    sbap_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold configuration, queue state, cost memory and the pacing divider
    sbap_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

// ===== sv/sbap_ctrl.sv =====
module sbap_ctrl import sbap_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sbap_func_t s_func,
    output logic       m_valid,
    input  logic       m_ready,
    input  sbap_stat_t stat,
    output sbap_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EXEC = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_func == FUNC_TX_DONE && stat.pace_on) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = DIV_CNT_W'(DIV_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_EXEC;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/sbap_datapath.sv =====
module sbap_datapath import sbap_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  sbap_in_t              s_data,
    input  sbap_cmd_t             cmd,
    output sbap_stat_t            stat,
    output sbap_out_t             m_data
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = FW + 1;

    // Configuration
    logic [BACKLOG_W-1:0] max_backlog_reg;
    logic [RATE_W-1:0]    rate_limit_reg;
    logic                 throttle_reg;
    logic                 lossy_reg;

    // Channel state
    logic [IW-1:0]        head_reg, head_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [BACKLOG_W-1:0] backlog_reg, backlog_next;
    logic                 stopped_reg, stopped_next;
    logic [SENT_W-1:0]    sent_reg, sent_next;

    // Item and pacing divider
    sbap_in_t             item_reg;
    logic [NS_W-1:0]      quot_reg;
    logic [RATE_W-1:0]    rem_reg;
    sbap_out_t            out_reg, out_next;

    // Cost queue
    logic [COST_W-1:0]    cost_mem [QUEUE_DEPTH];
    logic [COST_W-1:0]    rd_cost_reg;
    logic                 mem_we;
    logic [IW-1:0]        slot;

    logic [COST_W-1:0]    cost;
    logic [BACKLOG_W:0]   backlog_add;
    logic [BACKLOG_W-1:0] backlog_sat;
    logic [SW-1:0]        slot_sum;
    logic [SENT_W:0]      sent_add;
    logic [RATE_W-1:0]    rate_eff;
    logic [RATE_W:0]      trial;
    logic                 trial_ge;
    logic [NS_W-1:0]      delay_calc;
    logic [FW+QCOUNT_W-1:0] fill_ext;

    assign stat.pace_on = throttle_reg && !stopped_reg;
    assign m_data       = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_backlog_reg <= MAX_BACKLOG_RST;
            rate_limit_reg  <= RATE_LIMIT_RST;
            throttle_reg    <= 1'b0;
            lossy_reg       <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (sbap_cfg_idx_t'(cfg_index))
                CFG_MAX_BACKLOG:     max_backlog_reg <= cfg_wdata[BACKLOG_W-1:0];
                CFG_RATE_LIMIT:      rate_limit_reg  <= cfg_wdata[RATE_W-1:0];
                CFG_THROTTLE_ENABLE: throttle_reg    <= cfg_wdata[0];
                CFG_LOSSY_MODE:      lossy_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Restoring division: allocated = byte_count * 1e9 / rate
    assign rate_eff = (rate_limit_reg == '0) ? RATE_W'(1) : rate_limit_reg;
    assign trial    = {rem_reg, quot_reg[NS_W-1]};
    assign trial_ge = (trial >= {1'b0, rate_eff});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.mul) begin
            quot_reg <= NS_W'(item_reg.byte_count) * NS_W'(NANOS_PER_SEC);
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            quot_reg <= {quot_reg[NS_W-2:0], trial_ge};
            rem_reg  <= trial_ge ? RATE_W'(trial - {1'b0, rate_eff}) : trial[RATE_W-1:0];
        end
    end

    assign delay_calc = (quot_reg > item_reg.elapsed_ns) ? quot_reg - item_reg.elapsed_ns : '0;

    always_comb begin
        cost        = COST_W'(item_reg.payload_cost) + COST_W'(ENTRY_OVERHEAD);
        backlog_add = {1'b0, backlog_reg} + (BACKLOG_W + 1)'(cost);
        backlog_sat = backlog_add[BACKLOG_W] ? '1 : backlog_add[BACKLOG_W-1:0];
        slot_sum    = SW'(head_reg) + SW'(fill_reg);
        slot        = (slot_sum >= SW'(QUEUE_DEPTH)) ? IW'(slot_sum - SW'(QUEUE_DEPTH))
                                                     : IW'(slot_sum);
        sent_add    = {1'b0, sent_reg} + (SENT_W + 1)'(item_reg.byte_count);

        head_next    = head_reg;
        fill_next    = fill_reg;
        backlog_next = backlog_reg;
        stopped_next = stopped_reg;
        sent_next    = sent_reg;
        mem_we       = 1'b0;
        out_next.status   = STAT_PACED;
        out_next.delay_ns = '0;

        unique case (item_reg.func)
            FUNC_SUBMIT: begin
                if (stopped_reg) begin
                    out_next.status = STAT_ABORTED;
                end else if (!item_reg.closing && fill_reg != '0
                             && backlog_sat > max_backlog_reg) begin
                    if (lossy_reg) begin
                        out_next.status = STAT_DROPPED;
                    end else begin
                        stopped_next    = 1'b1;
                        out_next.status = STAT_BACKLOG_STOP;
                    end
                end else if (fill_reg >= FW'(QUEUE_DEPTH)) begin
                    out_next.status = STAT_DROPPED;
                end else begin
                    mem_we          = 1'b1;
                    fill_next       = fill_reg + 1'b1;
                    backlog_next    = backlog_sat;
                    out_next.status = (fill_reg != '0) ? STAT_QUEUED : STAT_STARTED;
                end
            end
            FUNC_TX_DONE: begin
                sent_next = sent_add[SENT_W] ? '1 : sent_add[SENT_W-1:0];
                if (stat.pace_on) begin
                    out_next.delay_ns = delay_calc;
                end
                out_next.status = STAT_PACED;
            end
            FUNC_COMPLETE: begin
                if (fill_reg == '0) begin
                    out_next.status = STAT_EMPTY;
                end else begin
                    // floor at zero
                    backlog_next = (backlog_reg > BACKLOG_W'(rd_cost_reg))
                                 ? backlog_reg - BACKLOG_W'(rd_cost_reg) : '0;
                    head_next    = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    fill_next    = fill_reg - 1'b1;
                    out_next.status = (fill_reg != FW'(1)) ? STAT_NEXT_STARTED : STAT_IDLE;
                end
            end
            FUNC_STOP: begin
                stopped_next    = 1'b1;
                out_next.status = STAT_STOPPED;
            end
            default: ;
        endcase

        fill_ext             = {{QCOUNT_W{1'b0}}, fill_next};
        out_next.backlog_now = backlog_next;
        out_next.queue_count = fill_ext[QCOUNT_W-1:0];
        out_next.sent_total  = sent_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            fill_reg    <= '0;
            backlog_reg <= '0;
            stopped_reg <= 1'b0;
            sent_reg    <= '0;
        end else if (cmd.commit) begin
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            backlog_reg <= backlog_next;
            stopped_reg <= stopped_next;
            sent_reg    <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && mem_we) begin
            cost_mem[slot] <= cost;
        end
        rd_cost_reg <= cost_mem[head_reg];
    end

endmodule

// ===== sim/sbap_report_checker.sv =====
`timescale 1ns / 100ps

module sbap_report_checker import sbap_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  sbap_in_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  sbap_out_t             m_data,
    output int                    mismatch_cnt,
    output int                    pending_cnt,
    output int                    reports_checked,
    output logic [9:0]            status_seen
);

    localparam logic [63:0] NS_PER_S = 64'd1_000_000_000;

    // Shadow of the block state and its registers
    logic [COST_W-1:0]    cost_q[$];
    logic [BACKLOG_W-1:0] backlog;
    logic                 halted;
    logic [SENT_W-1:0]    sent;
    logic [BACKLOG_W-1:0] max_backlog;
    logic [RATE_W-1:0]    rate;
    logic                 throttle;
    logic                 lossy;

    sbap_out_t            predicted_reports[$];

    function automatic sbap_out_t step_admission(input sbap_in_t ev);
        sbap_out_t            rpt;
        logic [COST_W-1:0]    cost;
        logic [COST_W-1:0]    head;
        logic [BACKLOG_W:0]   grown;
        logic [BACKLOG_W-1:0] sat_sum;
        logic [SENT_W:0]      sent_sum;
        logic [63:0]          divisor;
        logic [63:0]          allotted;
        logic                 busy;
        rpt     = '0;
        cost    = ev.payload_cost + ENTRY_OVERHEAD;
        busy    = (cost_q.size() != 0);
        grown   = backlog + cost;
        sat_sum = grown[BACKLOG_W] ? '1 : grown[BACKLOG_W-1:0];
        rpt.status = STAT_STARTED;
        case (ev.func)
            FUNC_SUBMIT: begin
                if (halted) begin
                    rpt.status = STAT_ABORTED;
                end else if (!ev.closing && busy && sat_sum > max_backlog) begin
                    if (lossy) begin
                        rpt.status = STAT_DROPPED;
                    end else begin
                        halted     = 1'b1;
                        rpt.status = STAT_BACKLOG_STOP;
                    end
                end else if (cost_q.size() >= QUEUE_DEPTH_DEF) begin
                    rpt.status = STAT_DROPPED;
                end else begin
                    cost_q.insert(cost_q.size(), cost);
                    backlog    = sat_sum;
                    rpt.status = busy ? STAT_QUEUED : STAT_STARTED;
                end
            end
            FUNC_TX_DONE: begin
                sent_sum = sent + ev.byte_count;
                sent     = sent_sum[SENT_W] ? '1 : sent_sum[SENT_W-1:0];
                if (throttle && !halted) begin
                    divisor  = (rate == '0) ? 64'd1 : 64'(rate);
                    allotted = 64'(ev.byte_count) * NS_PER_S / divisor;
                    if (allotted > 64'(ev.elapsed_ns))
                        rpt.delay_ns = NS_W'(allotted - 64'(ev.elapsed_ns));
                end
                rpt.status = STAT_PACED;
            end
            FUNC_COMPLETE: begin
                if (!busy) begin
                    rpt.status = STAT_EMPTY;
                end else begin
                    head = cost_q[0];
                    cost_q.delete(0);
                    backlog = (backlog > head) ? backlog - head : '0;
                    rpt.status = (cost_q.size() != 0) ? STAT_NEXT_STARTED : STAT_IDLE;
                end
            end
            default: begin
                halted     = 1'b1;
                rpt.status = STAT_STOPPED;
            end
        endcase
        rpt.backlog_now = backlog;
        rpt.queue_count = QCOUNT_W'(cost_q.size());
        rpt.sent_total  = sent;
        return rpt;
    endfunction

    always @(posedge aclk) begin : watch
        sbap_out_t want;
        if (!aresetn) begin
            cost_q.delete();
            predicted_reports.delete();
            backlog         = '0;
            halted          = 1'b0;
            sent            = '0;
            max_backlog     = MAX_BACKLOG_RST;
            rate            = RATE_LIMIT_RST;
            throttle        = 1'b0;
            lossy           = 1'b0;
            mismatch_cnt    = 0;
            reports_checked = 0;
            status_seen     = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_BACKLOG:     max_backlog = cfg_wdata[BACKLOG_W-1:0];
                    CFG_RATE_LIMIT:      rate        = cfg_wdata[RATE_W-1:0];
                    CFG_THROTTLE_ENABLE: throttle    = cfg_wdata[0];
                    default:             lossy       = cfg_wdata[0];
                endcase
            end
            if (s_valid && s_ready)
                predicted_reports.insert(predicted_reports.size(), step_admission(s_data));
            if (m_valid && m_ready) begin
                reports_checked++;
                if (m_data.status <= STAT_STOPPED)
                    status_seen[m_data.status] = 1'b1;
                if (predicted_reports.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected report, status %0d", $time, m_data.status);
                end else begin
                    want = predicted_reports[0];
                    predicted_reports.delete(0);
                    if (want.status !== m_data.status || want.delay_ns !== m_data.delay_ns ||
                        want.backlog_now !== m_data.backlog_now ||
                        want.queue_count !== m_data.queue_count ||
                        want.sent_total !== m_data.sent_total) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"%0t: report mismatch: status %0d/%0d delay %0d/%0d ",
                                      "backlog %0d/%0d count %0d/%0d sent %0d/%0d (exp/got)"},
                                     $time, want.status, m_data.status,
                                     want.delay_ns, m_data.delay_ns,
                                     want.backlog_now, m_data.backlog_now,
                                     want.queue_count, m_data.queue_count,
                                     want.sent_total, m_data.sent_total);
                    end
                end
            end
        end
        pending_cnt = predicted_reports.size();
    end

endmodule

// ===== sim/send_backlog_admission_pacer_core_tb.sv =====
`timescale 1ns / 100ps

module send_backlog_admission_pacer_core_tb;
    import sbap_pkg::*;

    // Hold-off length for the long receiver stall
    localparam int HOLD_CYCLES  = 300;
    // Cycles to keep watching after the last report, longer than a paced divide
    localparam int DRAIN_CYCLES = 80;
    // Watchdog limit, well above the slowest correct run
    localparam int CYCLE_LIMIT  = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    sbap_in_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    sbap_out_t             m_data;

    int         mismatch_cnt;
    int         pending_cnt;
    int         reports_checked;
    logic [9:0] status_seen;

    int cycle_cnt;
    int items_sent;
    int holds_asked;
    bit tx_burst;

    send_backlog_admission_pacer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Watch both channels and the register port, predict and compare
    sbap_report_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_cnt    (mismatch_cnt),
        .pending_cnt     (pending_cnt),
        .reports_checked (reports_checked),
        .status_seen     (status_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    // Kill a hung run
    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d reports outstanding", cycle_cnt, pending_cnt);
        $display("** send_backlog_admission_pacer_core: FAILED **");
        $finish;
    end

    // Result sink: draw a stall before each transfer, switch to back-to-back
    // stretches now and then, and honor a long hold-off when asked.
    initial begin : result_sink
        int gap;
        int holds_done;
        bit rx_burst;
        m_ready    = 1'b0;
        gap        = 0;
        holds_done = 0;
        rx_burst   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                gap        = HOLD_CYCLES;
                holds_done = holds_asked;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if ($urandom_range(0, 19) == 0)
                    rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, 16);
            end
        end
    end

    function automatic sbap_in_t build_event(input sbap_func_t f, input logic [31:0] cost,
                                             input logic last, input logic [31:0] nbytes,
                                             input logic [NS_W-1:0] ns);
        sbap_in_t ev;
        ev.func         = f;
        ev.payload_cost = cost;
        ev.closing      = last;
        ev.byte_count   = nbytes;
        ev.elapsed_ns   = ns;
        return ev;
    endfunction

    // Weighted random event; every field is filled whatever the function,
    // mixing small values, full-width values and the extremes.
    function automatic sbap_in_t draw_event(input int w_submit, input int w_done,
                                            input int w_compl, input int w_stop);
        sbap_in_t    ev;
        int          pick;
        logic [63:0] wide;
        pick = $urandom_range(1, w_submit + w_done + w_compl + w_stop);
        if (pick <= w_submit)
            ev.func = FUNC_SUBMIT;
        else if (pick <= w_submit + w_done)
            ev.func = FUNC_TX_DONE;
        else if (pick <= w_submit + w_done + w_compl)
            ev.func = FUNC_COMPLETE;
        else
            ev.func = FUNC_STOP;
        case ($urandom_range(0, 3))
            0:       ev.payload_cost = $urandom_range(0, 2000);
            1:       ev.payload_cost = $urandom;
            2:       ev.payload_cost = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: ev.payload_cost = $urandom_range(0, 65535);
        endcase
        ev.closing = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 2))
            0:       ev.byte_count = $urandom;
            1:       ev.byte_count = $urandom_range(0, 1500);
            default: ev.byte_count = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       ev.elapsed_ns = wide[NS_W-1:0];
            1:       ev.elapsed_ns = NS_W'($urandom);
            2:       ev.elapsed_ns = NS_W'($urandom_range(0, 1000));
            3:       ev.elapsed_ns = '0;
            default: ev.elapsed_ns = '1;
        endcase
        return ev;
    endfunction

    // Offer one event after a random gap and hold it until the transfer.
    // Enter and leave on a falling edge.
    task automatic push_event(input sbap_in_t ev);
        int gap;
        if ($urandom_range(0, 19) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            s_valid <= 1'b0;
            s_data  <= draw_event(1, 1, 1, 1);
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic run_mix(input int count, input int w_submit, input int w_done,
                           input int w_compl, input int w_stop);
        repeat (count) push_event(draw_event(w_submit, w_done, w_compl, w_stop));
    endtask

    // Drop valid and wait until every report has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_cnt != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input sbap_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    // Program all four registers back to back; only while the block is idle
    task automatic set_mode(input logic [BACKLOG_W-1:0] limit, input logic [RATE_W-1:0] bps,
                            input logic pace, input logic drop_over);
        write_reg(CFG_MAX_BACKLOG, CFG_DATA_W'(limit));
        write_reg(CFG_RATE_LIMIT, CFG_DATA_W'(bps));
        write_reg(CFG_THROTTLE_ENABLE, CFG_DATA_W'(pace));
        write_reg(CFG_LOSSY_MODE, CFG_DATA_W'(drop_over));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int codes;
        int k;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_MAX_BACKLOG;
        cfg_wdata   = '0;
        items_sent  = 0;
        holds_asked = 0;
        tx_burst    = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: small limit, lossy, pacing at one byte per second
        set_mode(40'd4096, 32'd1, 1'b1, 1'b1);
        // completion on an empty queue
        push_event(build_event(FUNC_COMPLETE, 32'd0, 1'b0, 32'd0, '0));
        // first submit starts right away, zero payload still pays the overhead
        push_event(build_event(FUNC_SUBMIT, 32'd0, 1'b0, 32'd0, '0));
        // busy and over the limit: dropped in lossy mode
        push_event(build_event(FUNC_SUBMIT, 32'hFFFF_FFFF, 1'b0, 32'd0, '0));
        // closing message bypasses the limit
        push_event(build_event(FUNC_SUBMIT, 32'hFFFF_FFFF, 1'b1, 32'd0, '0));
        push_event(build_event(FUNC_SUBMIT, 32'd100, 1'b0, 32'd0, '0));
        // largest delay, a small positive one, one eaten by elapsed time, zero bytes
        push_event(build_event(FUNC_TX_DONE, 32'd0, 1'b0, 32'hFFFF_FFFF, '0));
        push_event(build_event(FUNC_TX_DONE, 32'd0, 1'b0, 32'd1000, NS_W'(5)));
        push_event(build_event(FUNC_TX_DONE, 32'd0, 1'b0, 32'd5, '1));
        push_event(build_event(FUNC_TX_DONE, 32'd0, 1'b0, 32'd0, '0));
        // pop down to empty and past it
        push_event(build_event(FUNC_COMPLETE, 32'd0, 1'b0, 32'd0, '0));
        push_event(build_event(FUNC_COMPLETE, 32'd0, 1'b0, 32'd0, '0));
        push_event(build_event(FUNC_COMPLETE, 32'd0, 1'b0, 32'd0, '0));
        // an idle queue admits any size
        push_event(build_event(FUNC_SUBMIT, 32'hFFFF_FFFF, 1'b0, 32'd0, '0));
        push_event(build_event(FUNC_COMPLETE, 32'd0, 1'b0, 32'd0, '0));
        settle();

        // No backlog limit, stop-on-overflow: submit-heavy so the queue fills
        // and drops on full. Stall the receiver long enough to back up the input.
        set_mode('1, $urandom, 1'b1, 1'b0);
        holds_asked++;
        run_mix(95, 85, 7, 8, 0);
        settle();

        // Modest limit, lossy, zero rate taken as one byte per second
        set_mode(BACKLOG_W'($urandom_range(0, 65536)), 32'd0, 1'b1, 1'b1);
        run_mix(85, 45, 20, 35, 0);
        settle();

        // Zero limit: every busy non-closing submit drops; no pacing, top rate
        set_mode('0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        run_mix(80, 50, 20, 30, 0);
        settle();

        // Random limit and rate
        set_mode({8'($urandom), 32'($urandom)}, $urandom_range(1, 100000), 1'b1, 1'b1);
        run_mix(85, 40, 30, 30, 0);
        settle();

        // Stopping behavior last: both stops are sticky until reset
        set_mode('0, $urandom_range(1, 1000), 1'b1, 1'b0);
        push_event(build_event(FUNC_SUBMIT, 32'd10, 1'b0, 32'd0, '0));
        // over the zero limit while busy: stops the channel
        push_event(build_event(FUNC_SUBMIT, 32'd10, 1'b0, 32'd0, '0));
        // submits abort, pacing reads zero, completions and counting go on
        push_event(build_event(FUNC_SUBMIT, 32'd10, 1'b1, 32'd0, '0));
        push_event(build_event(FUNC_TX_DONE, 32'd0, 1'b0, 32'hFFFF_FFFF, '0));
        push_event(build_event(FUNC_COMPLETE, 32'd0, 1'b0, 32'd0, '0));
        push_event(build_event(FUNC_STOP, 32'd0, 1'b0, 32'd0, '0));
        run_mix(60, 30, 30, 30, 10);
        settle();

        repeat (DRAIN_CYCLES) @(negedge aclk);

        codes = 0;
        for (k = 0; k < 10; k++)
            if (status_seen[k]) codes++;
        $display("Covered %0d events over six register settings, incl. a %0d-cycle result stall.",
                 items_sent, HOLD_CYCLES);
        $display("Checked %0d reports, %0d of 10 status codes seen, %0d mismatches.",
                 reports_checked, codes, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("** send_backlog_admission_pacer_core: PASSED **");
        end else begin
            $display("** send_backlog_admission_pacer_core: FAILED **");
        end
        $finish;
    end

endmodule
